FILE: hw/rtl/chorus_modulated_delay_unit_assert.svh
// assertion macros shared by the chorus checker
// expects clk and arst_n in the scope where a macro is used
`ifndef CHORUS_MODULATED_DELAY_UNIT_ASSERT_SVH
`define CHORUS_MODULATED_DELAY_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHORUS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chorus check failed");

// next-cycle implication, sampled on clk, off during reset
`define CHORUS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chorus check failed");

`endif

FILE: hw/rtl/chorus_pkg.sv
// chorus package: sizes, register map, config struct and the sine table
// used by the chorus rtl files other than chorus_ram; depends on nothing
`timescale 1ns / 1ps

package chorus_pkg;

	localparam int HISTORY_DEPTH    = 4096;
	localparam int HIST_AW          = $clog2(HISTORY_DEPTH);
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);

	localparam int SAMPLE_W = 16;
	localparam int DELAY_W  = 20;
	localparam int GAIN_W   = 16;
	localparam int PHASE_W  = 32;
	localparam int FRAC_W   = 8;
	// read position in samples with fractional bits
	localparam int POS_W    = HIST_AW + FRAC_W;

	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = APB_AW - 2;

	localparam logic [REG_IDX_W-1:0] REG_ENABLE     = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_BASE_DELAY = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_MOD_DEPTH  = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_LFO_STEP   = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_DRY_GAIN   = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_WET_GAIN   = REG_IDX_W'(5);

	localparam logic [DELAY_W-1:0] RST_BASE_DELAY = DELAY_W'(225792);
	localparam logic [DELAY_W-1:0] RST_MOD_DEPTH  = DELAY_W'(112896);
	localparam logic [PHASE_W-1:0] RST_LFO_STEP   = PHASE_W'(19477);
	localparam logic [GAIN_W-1:0]  RST_DRY_GAIN   = GAIN_W'(14043);
	localparam logic [GAIN_W-1:0]  RST_WET_GAIN   = GAIN_W'(18725);

	// polynomial sine coefficients, q15
	localparam longint unsigned SIN_A = 51472;
	localparam longint unsigned SIN_B = 21024;
	localparam longint unsigned SIN_C = 2320;

	typedef struct packed {
		logic               enable;
		logic [DELAY_W-1:0] base_delay;
		logic [DELAY_W-1:0] mod_depth;
		logic [PHASE_W-1:0] lfo_step;
		logic [GAIN_W-1:0]  dry_gain;
		logic [GAIN_W-1:0]  wet_gain;
	} cfg_t;

	typedef logic signed [SAMPLE_W-1:0] sine_tbl_t [SINE_TABLE_DEPTH];

	function automatic sine_tbl_t build_sine();
		sine_tbl_t             tbl;
		logic [31:0]           u;
		logic [30:0]           r;
		longint unsigned       x;
		longint unsigned       x2;
		longint unsigned       t;
		longint unsigned       y;
		logic [SAMPLE_W-1:0]   mag;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			u = 32'(longint'(k) << (32 - SINE_AW));
			r = {1'b0, u[29:0]};
			// mirror odd quadrants so the peak lands on x = 32768
			if (u[30]) begin
				r = 31'h4000_0000 - r;
			end
			x   = longint'(r >> 15);
			x2  = (x * x) >> 15;
			t   = (SIN_C * x2) >> 15;
			t   = SIN_B - t;
			t   = (t * x2) >> 15;
			t   = SIN_A - t;
			y   = (t * x) >> 15;
			if (y > 32767) begin
				y = 32767;
			end
			mag = SAMPLE_W'(y);
			tbl[k] = u[31] ? -mag : mag;
		end
		return tbl;
	endfunction

	localparam sine_tbl_t SINE_TBL = build_sine();

endpackage

FILE: hw/rtl/chorus_ram.sv
// generic single-write, dual-read ram with registered read data
// no package dependency
`timescale 1ns / 1ps

module chorus_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: hw/rtl/chorus_regs.sv
// apb-style configuration registers of the chorus block
// depends on chorus_pkg for the register map and cfg_t
`timescale 1ns / 1ps

module chorus_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [chorus_pkg::APB_AW-1:0]  paddr,
	input  logic [chorus_pkg::APB_DW-1:0]  pwdata,
	output logic [chorus_pkg::APB_DW-1:0]  prdata,
	output logic                           pready,
	output chorus_pkg::cfg_t               cfg
);

	chorus_pkg::cfg_t                       cfg_q;
	logic [chorus_pkg::REG_IDX_W-1:0]       idx;
	logic                                   wr;

	assign pready = 1'b1;
	assign idx    = paddr[chorus_pkg::APB_AW-1:2];
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable     <= 1'b0;
			cfg_q.base_delay <= chorus_pkg::RST_BASE_DELAY;
			cfg_q.mod_depth  <= chorus_pkg::RST_MOD_DEPTH;
			cfg_q.lfo_step   <= chorus_pkg::RST_LFO_STEP;
			cfg_q.dry_gain   <= chorus_pkg::RST_DRY_GAIN;
			cfg_q.wet_gain   <= chorus_pkg::RST_WET_GAIN;
		end else if (wr) begin
			case (idx)
				chorus_pkg::REG_ENABLE: begin
					cfg_q.enable <= pwdata[0];
				end
				chorus_pkg::REG_BASE_DELAY: begin
					cfg_q.base_delay <= pwdata[chorus_pkg::DELAY_W-1:0];
				end
				chorus_pkg::REG_MOD_DEPTH: begin
					cfg_q.mod_depth <= pwdata[chorus_pkg::DELAY_W-1:0];
				end
				chorus_pkg::REG_LFO_STEP: begin
					cfg_q.lfo_step <= pwdata[chorus_pkg::PHASE_W-1:0];
				end
				chorus_pkg::REG_DRY_GAIN: begin
					cfg_q.dry_gain <= pwdata[chorus_pkg::GAIN_W-1:0];
				end
				chorus_pkg::REG_WET_GAIN: begin
					cfg_q.wet_gain <= pwdata[chorus_pkg::GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			chorus_pkg::REG_ENABLE: begin
				prdata = chorus_pkg::APB_DW'(cfg_q.enable);
			end
			chorus_pkg::REG_BASE_DELAY: begin
				prdata = chorus_pkg::APB_DW'(cfg_q.base_delay);
			end
			chorus_pkg::REG_MOD_DEPTH: begin
				prdata = chorus_pkg::APB_DW'(cfg_q.mod_depth);
			end
			chorus_pkg::REG_LFO_STEP: begin
				prdata = chorus_pkg::APB_DW'(cfg_q.lfo_step);
			end
			chorus_pkg::REG_DRY_GAIN: begin
				prdata = chorus_pkg::APB_DW'(cfg_q.dry_gain);
			end
			chorus_pkg::REG_WET_GAIN: begin
				prdata = chorus_pkg::APB_DW'(cfg_q.wet_gain);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/chorus_modulated_delay_unit.sv
// chorus_modulated_delay_unit: top level of the sine-lfo chorus
// depends on chorus_pkg, chorus_regs and chorus_ram
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------
//   input   | in_valid / in_ready        | sample_in  (16 bit signed)
//   output  | out_valid / out_ready      | sample_out (16 bit signed)
//   config  | psel, penable, pwrite, ... | paddr, pwdata, prdata (32 bit)
//
// items are taken one at a time: a new item is accepted only once the previous one has
// left the eight-step sequence around the history memory (write, swing multiply, delay
// clamp, read, interpolate, mix, saturate, scale) and reached the output register.
// history is not cleared at reset: a fill counter makes entries not yet written read
// as zero, so the block is ready right after reset.
// a finished result waits in the output register while the next item is accepted;
// the sequence holds at its last step only if that register is still full.
`timescale 1ns / 1ps

module chorus_modulated_delay_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [chorus_pkg::APB_AW-1:0]         paddr,
	input  logic [chorus_pkg::APB_DW-1:0]         pwdata,
	output logic [chorus_pkg::APB_DW-1:0]         prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [chorus_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [chorus_pkg::SAMPLE_W-1:0] sample_out
);

	localparam int SW       = chorus_pkg::SAMPLE_W;
	localparam int AW       = chorus_pkg::HIST_AW;
	localparam int PW       = chorus_pkg::POS_W;
	localparam int FW       = chorus_pkg::FRAC_W;
	localparam int PROD_DW  = chorus_pkg::DELAY_W + 1 + SW;   // depth x sine
	localparam int SWING_W  = PROD_DW - 15;
	localparam int DSUM_W   = SWING_W + 1;
	localparam int INTERP_W = SW + FW + 2;
	localparam int DRY_W    = SW + chorus_pkg::GAIN_W + 1;
	localparam int WET_W    = INTERP_W + chorus_pkg::GAIN_W + 1;
	localparam int ACC_W    = WET_W;
	localparam int SCALE_SH = 38;
	localparam int M_W      = SCALE_SH + 2;
	localparam int PROD_W   = M_W + 15;
	localparam longint MAX_DELAY = longint'(chorus_pkg::HISTORY_DEPTH - 1) << FW;
	localparam longint ACC_LIM   = 64'sd1 <<< SCALE_SH;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_DLY, S_ADR, S_INT, S_MIX, S_SAT, S_OUT
	} state_t;

	chorus_pkg::cfg_t cfg;

	state_t                  state_q;
	logic                    out_valid_q;
	logic signed [SW-1:0]    out_data_q;

	logic [AW-1:0]           wp_q;
	logic [AW:0]             fill_q;
	logic [chorus_pkg::PHASE_W-1:0] phase_q;

	logic signed [SW-1:0]    x_s1;
	logic [AW-1:0]           wp_s1;
	logic signed [SW-1:0]    sine_s1;
	logic                    en_s1;
	logic signed [PROD_DW-1:0] p_s2;
	logic [PW-1:0]           d_s3;
	logic [FW-1:0]           f_s4;
	logic                    v1_s4;
	logic                    v2_s4;
	logic signed [INTERP_W-1:0] interp_s5;
	logic signed [DRY_W-1:0] dry_s5;
	logic signed [ACC_W-1:0] acc_s6;
	logic signed [PROD_W-1:0] prod_s7;

	logic                    accept;
	logic [SW-1:0]           h1_raw;
	logic [SW-1:0]           h2_raw;
	logic [PW-1:0]           rp;
	logic [AW-1:0]           rd_i1;
	logic [AW-1:0]           rd_i2;

	logic signed [PROD_DW-1:0]  p_mul;
	logic signed [SWING_W-1:0]  swing;
	logic signed [DSUM_W-1:0]   dsum;
	logic [PW-1:0]              d_clamp;
	logic signed [SW-1:0]       h1;
	logic signed [SW-1:0]       h2;
	logic [FW:0]                w1;
	logic signed [INTERP_W-1:0] t1;
	logic signed [INTERP_W-1:0] t2;
	logic signed [DRY_W-1:0]    dry_mul;
	logic signed [WET_W-1:0]    wet_mul;
	logic signed [ACC_W-1:0]    dry_ext;
	logic signed [M_W-1:0]      m_sat;
	logic signed [PROD_W-1:0]   bias;
	logic signed [PROD_W-1:0]   scaled;
	logic signed [SW-1:0]       result;

	chorus_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	chorus_ram #(
		.WIDTH (SW),
		.DEPTH (chorus_pkg::HISTORY_DEPTH)
	) u_hist (
		.clk     (clk),
		.we      (accept),
		.waddr   (wp_q),
		.wdata   (sample_in),
		.raddr_a (rd_i1),
		.rdata_a (h1_raw),
		.raddr_b (rd_i2),
		.rdata_b (h2_raw)
	);

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;

	// read position wraps modulo the store size for free
	assign rp    = {wp_s1, {FW{1'b0}}} - d_s3;
	assign rd_i1 = rp[PW-1:FW];
	assign rd_i2 = rd_i1 + 1'b1;

	always_comb begin
		p_mul = $signed({1'b0, cfg.mod_depth}) * sine_s1;

		swing = SWING_W'(p_s2 >>> 15);
		dsum  = $signed({{(DSUM_W - chorus_pkg::DELAY_W){1'b0}}, cfg.base_delay}) + swing;
		if (dsum < 0) begin
			d_clamp = '0;
		end else if (dsum > MAX_DELAY) begin
			d_clamp = PW'(MAX_DELAY);
		end else begin
			d_clamp = PW'(dsum);
		end

		// entries never written read as zero
		h1 = v1_s4 ? $signed(h1_raw) : '0;
		h2 = v2_s4 ? $signed(h2_raw) : '0;
		w1 = (FW + 1)'(1 << FW) - {1'b0, f_s4};
		t1 = h1 * $signed({1'b0, w1});
		t2 = h2 * $signed({2'b0, f_s4});

		dry_mul = x_s1 * $signed({1'b0, cfg.dry_gain});
		wet_mul = interp_s5 * $signed({1'b0, cfg.wet_gain});
		dry_ext = $signed({{(ACC_W - DRY_W - FW){dry_s5[DRY_W-1]}}, dry_s5, {FW{1'b0}}});

		if (acc_s6 > ACC_LIM) begin
			m_sat = M_W'(ACC_LIM);
		end else if (acc_s6 < -ACC_LIM) begin
			m_sat = M_W'(-ACC_LIM);
		end else begin
			m_sat = M_W'(acc_s6);
		end

		// shift toward zero for negative values
		bias   = prod_s7[PROD_W-1] ? PROD_W'(ACC_LIM - 1) : '0;
		scaled = (prod_s7 + bias) >>> SCALE_SH;
		result = en_s1 ? SW'(scaled) : x_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			fill_q  <= '0;
			phase_q <= '0;
		end else if (accept) begin
			wp_q <= wp_q + 1'b1;
			if (!fill_q[AW]) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cfg.enable) begin
				phase_q <= phase_q + cfg.lfo_step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= sample_in;
			wp_s1   <= wp_q;
			en_s1   <= cfg.enable;
			sine_s1 <= chorus_pkg::SINE_TBL[phase_q[chorus_pkg::PHASE_W-1 -: chorus_pkg::SINE_AW]];
		end
		case (state_q)
			S_MUL: begin
				p_s2 <= p_mul;
			end
			S_DLY: begin
				d_s3 <= d_clamp;
			end
			S_ADR: begin
				f_s4  <= rp[FW-1:0];
				v1_s4 <= fill_q[AW] || (rd_i1 < fill_q[AW-1:0]);
				v2_s4 <= fill_q[AW] || (rd_i2 < fill_q[AW-1:0]);
			end
			S_INT: begin
				interp_s5 <= t1 + t2;
				dry_s5    <= dry_mul;
			end
			S_MIX: begin
				acc_s6 <= dry_ext + wet_mul;
			end
			S_SAT: begin
				prod_s7 <= (PROD_W'(m_sat) <<< 15) - PROD_W'(m_sat);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// the last step reloads the register itself when it drains
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DLY;
				end
				S_DLY: begin
					state_q <= S_ADR;
				end
				S_ADR: begin
					state_q <= S_INT;
				end
				S_INT: begin
					state_q <= S_MIX;
				end
				S_MIX: begin
					state_q <= S_SAT;
				end
				S_SAT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= result;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/chorus_chk.sv
// port-level checker for the chorus block, bound to the top level
// depends on chorus_pkg and chorus_modulated_delay_unit_assert.svh
`timescale 1ns / 1ps
`include "chorus_modulated_delay_unit_assert.svh"

module chorus_chk (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [chorus_pkg::SAMPLE_W-1:0] sample_out,
	input logic                                   pready
);

	// a stalled result item holds
	`CHORUS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out))

	// one item in flight: no second accept right after the first
	`CHORUS_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// a result never shows up the cycle after its item was taken
	`CHORUS_ASSERT_IMP(a_min_latency, $rose(out_valid), !$past(in_valid && in_ready, 1))

	// config port never inserts wait states
	`CHORUS_ASSERT_IMP(a_pready, 1'b1, pready)

endmodule

bind chorus_modulated_delay_unit chorus_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out),
	.pready     (pready)
);

FILE: tb/chorus_delay_checker.sv
// chorus_delay_checker: watches the apb port and both sample channels of the chorus,
// predicts every output sample and compares it, register reads included
// depends on chorus_pkg for sizes, register indexes and the config struct
`timescale 1ns / 1ps

module chorus_delay_checker
	import chorus_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_AW-1:0]          paddr,
	input  logic [APB_DW-1:0]          pwdata,
	input  logic [APB_DW-1:0]          prdata,
	input  logic                       pready,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [SAMPLE_W-1:0] sample_out,
	output int                         fail_count,
	output int                         pending,
	output int                         sample_count,
	output int                         result_count,
	output int                         write_count
);

	cfg_t                       regs;
	logic signed [SAMPLE_W-1:0] hist [HISTORY_DEPTH];
	logic signed [SAMPLE_W-1:0] sine_lut [SINE_TABLE_DEPTH];
	logic [HIST_AW-1:0]         wr_pos;
	logic [PHASE_W-1:0]         phase;
	logic signed [SAMPLE_W-1:0] expected_mix [$];
	int                         errs;
	int                         n_in;
	int                         n_out;
	int                         n_wr;

	function automatic logic signed [SAMPLE_W-1:0] lfo_sine(input int k);
		logic [31:0]                u;
		logic [31:0]                r;
		longint unsigned            x;
		longint unsigned            x2;
		longint unsigned            t;
		longint unsigned            y;
		logic signed [SAMPLE_W-1:0] mag;
		u = 32'((longint'(k) << 32) / SINE_TABLE_DEPTH);
		r = {2'b00, u[29:0]};
		// odd quadrants run backwards toward the peak
		if (u[30]) begin
			r = 32'h4000_0000 - r;
		end
		x  = longint'(r >> 15);
		x2 = (x * x) >> 15;
		t  = (SIN_C * x2) >> 15;
		t  = SIN_B - t;
		t  = (t * x2) >> 15;
		t  = SIN_A - t;
		y  = (t * x) >> 15;
		if (y > 32767) begin
			y = 32767;
		end
		mag = $signed(SAMPLE_W'(y));
		return u[31] ? -mag : mag;
	endfunction

	initial begin
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			sine_lut[k] = lfo_sine(k);
		end
	end

	// store the sample, then work out the delayed tap and the wet/dry mix (pass-through when disabled)
	function automatic logic signed [SAMPLE_W-1:0] chorus_sample(
		input logic signed [SAMPLE_W-1:0] x
	);
		logic [HIST_AW-1:0]         wp;
		longint                     k;
		longint                     swing;
		longint                     d;
		longint                     rp;
		longint                     i1;
		longint                     i2;
		longint                     f;
		longint                     h1;
		longint                     h2;
		longint                     interp;
		longint                     acc;
		longint                     acc_lim;
		longint                     res;
		logic signed [SAMPLE_W-1:0] y;
		wp = wr_pos;
		hist[wp] = x;
		if (!regs.enable) begin
			y = x;
		end else begin
			k = (longint'(phase) * SINE_TABLE_DEPTH) >> 32;
			swing = (longint'(regs.mod_depth) * longint'(sine_lut[k])) >>> 15;
			phase = phase + regs.lfo_step;
			d = longint'(regs.base_delay) + swing;
			if (d < 0) begin
				d = 0;
			end
			if (d > longint'(HISTORY_DEPTH - 1) * 256) begin
				d = longint'(HISTORY_DEPTH - 1) * 256;
			end
			rp = longint'(wp) * 256 - d;
			if (rp < 0) begin
				rp = rp + longint'(HISTORY_DEPTH) * 256;
			end
			i1 = (rp / 256) % HISTORY_DEPTH;
			f  = rp % 256;
			i2 = (i1 + 1) % HISTORY_DEPTH;
			h1 = hist[i1];
			h2 = hist[i2];
			interp = h1 * (256 - f) + h2 * f;
			acc = longint'(x) * longint'(regs.dry_gain) * 256
				+ interp * longint'(regs.wet_gain);
			acc_lim = longint'(1) << 38;
			if (acc > acc_lim) begin
				acc = acc_lim;
			end
			if (acc < -acc_lim) begin
				acc = -acc_lim;
			end
			res = (acc * 32767) / acc_lim;
			y = SAMPLE_W'(res);
		end
		wr_pos = wp + 1'b1;
		return y;
	endfunction

	function automatic logic [APB_DW-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_ENABLE:     return APB_DW'(regs.enable);
			REG_BASE_DELAY: return APB_DW'(regs.base_delay);
			REG_MOD_DEPTH:  return APB_DW'(regs.mod_depth);
			REG_LFO_STEP:   return APB_DW'(regs.lfo_step);
			REG_DRY_GAIN:   return APB_DW'(regs.dry_gain);
			REG_WET_GAIN:   return APB_DW'(regs.wet_gain);
			default:        return '0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_W-1:0] want;
		logic [REG_IDX_W-1:0]       idx;
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist[i] = '0;
			end
			wr_pos          = '0;
			phase           = '0;
			regs.enable     = 1'b0;
			regs.base_delay = RST_BASE_DELAY;
			regs.mod_depth  = RST_MOD_DEPTH;
			regs.lfo_step   = RST_LFO_STEP;
			regs.dry_gain   = RST_DRY_GAIN;
			regs.wet_gain   = RST_WET_GAIN;
			expected_mix.delete();
			errs  = 0;
			n_in  = 0;
			n_out = 0;
			n_wr  = 0;
			fail_count   <= 0;
			pending      <= 0;
			sample_count <= 0;
			result_count <= 0;
			write_count  <= 0;
		end else begin
			idx = paddr[APB_AW-1:2];
			if (psel && penable && pready) begin
				if (pwrite) begin
					n_wr++;
					case (idx)
						REG_ENABLE:     regs.enable     = pwdata[0];
						REG_BASE_DELAY: regs.base_delay = pwdata[DELAY_W-1:0];
						REG_MOD_DEPTH:  regs.mod_depth  = pwdata[DELAY_W-1:0];
						REG_LFO_STEP:   regs.lfo_step   = pwdata[PHASE_W-1:0];
						REG_DRY_GAIN:   regs.dry_gain   = pwdata[GAIN_W-1:0];
						REG_WET_GAIN:   regs.wet_gain   = pwdata[GAIN_W-1:0];
						default: ;
					endcase
				end else if (idx <= REG_WET_GAIN && prdata !== reg_value(idx)) begin
					errs++;
					$error("prdata (reg %0d): expected %0h, actual %0h",
						idx, reg_value(idx), prdata);
				end
			end
			if (in_valid && in_ready) begin
				n_in++;
				expected_mix.push_back(chorus_sample(sample_in));
			end
			if (out_valid && out_ready) begin
				n_out++;
				if (expected_mix.size() == 0) begin
					errs++;
					$error("sample_out: expected no item, actual %0d", sample_out);
				end else begin
					want = expected_mix.pop_front();
					if (sample_out !== want) begin
						errs++;
						$error("sample_out: expected %0d, actual %0d", want, sample_out);
					end
				end
			end
			fail_count   <= errs;
			pending      <= expected_mix.size();
			sample_count <= n_in;
			result_count <= n_out;
			write_count  <= n_wr;
		end
	end

endmodule

FILE: tb/tb_chorus_modulated_delay_unit.sv
// tb_chorus_modulated_delay_unit: clock, reset, apb programming and sample traffic
// for the chorus block; depends on chorus_pkg, chorus_delay_checker and the rtl
`timescale 1ns / 1ps

module tb_chorus_modulated_delay_unit;
	import chorus_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_PHASES = 11;
	localparam int PHASE_ITEMS   = 150;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = REG_IDX_W'(REG_WET_GAIN + 1);
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = REG_IDX_W'(REG_WET_GAIN + 2);

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [APB_AW-1:0]          paddr;
	logic [APB_DW-1:0]          pwdata;
	logic [APB_DW-1:0]          prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       quiet;
	int                         fail_count;
	int                         pending;
	int                         sample_count;
	int                         result_count;
	int                         write_count;
	int                         idle_cycles = 0;

	always #5 clk = ~clk;

	chorus_modulated_delay_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	chorus_delay_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.fail_count   (fail_count),
		.pending      (pending),
		.sample_count (sample_count),
		.result_count (result_count),
		.write_count  (write_count)
	);

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold the sender until every item has come back out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_back_regs();
		for (int i = REG_ENABLE; i <= REG_WET_GAIN; i++) begin
			@(posedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= {REG_IDX_W'(i), 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic program_regs(input cfg_t c);
		drain_results();
		apb_write(REG_ENABLE,     APB_DW'(c.enable));
		apb_write(REG_BASE_DELAY, APB_DW'(c.base_delay));
		apb_write(REG_MOD_DEPTH,  APB_DW'(c.mod_depth));
		apb_write(REG_LFO_STEP,   APB_DW'(c.lfo_step));
		apb_write(REG_DRY_GAIN,   APB_DW'(c.dry_gain));
		apb_write(REG_WET_GAIN,   APB_DW'(c.wet_gain));
		read_back_regs();
	endtask

	initial begin : result_sink
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("chorus_modulated_delay_unit regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		cfg_t                       c;
		logic signed [SAMPLE_W-1:0] v;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		sample_in = '0;
		quiet     = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through at reset settings, fills the first history entries
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sh0000);
		send_sample(16'shFFFF);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);

		// zero delay reads back the sample just stored
		c = '{enable: 1'b1, base_delay: '0, mod_depth: '0, lfo_step: '0,
			dry_gain: 16'd32768, wet_gain: 16'd32768};
		program_regs(c);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh04D2);

		// half-sample delay blends the previous and current entries
		c = '{enable: 1'b1, base_delay: 20'd128, mod_depth: '0, lfo_step: '0,
			dry_gain: '0, wet_gain: 16'd32768};
		program_regs(c);
		send_sample(16'sh1000);
		send_sample(16'shF000);

		// quarter-turn steps walk zero, peak, zero, trough: both delay clamps
		c = '{enable: 1'b1, base_delay: 20'd256, mod_depth: 20'hFFFFF,
			lfo_step: 32'h4000_0000, dry_gain: 16'd16384, wet_gain: 16'd16384};
		program_regs(c);
		repeat (4) send_sample(16'($urandom));

		c = '{enable: 1'b1, base_delay: 20'hFFFFF, mod_depth: '0,
			lfo_step: 32'hFFFF_FFFF, dry_gain: '0, wet_gain: 16'd16384};
		program_regs(c);
		send_sample(16'sh2345);
		send_sample(16'shDCBA);

		// amplifying gains drive the mix into saturation both ways
		c = '{enable: 1'b1, base_delay: 20'd512, mod_depth: 20'd256,
			lfo_step: 32'h0100_0000, dry_gain: 16'hFFFF, wet_gain: 16'hFFFF};
		program_regs(c);
		send_sample(16'sh7FFF);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh8000);

		// writes to unmapped indexes must leave every register alone
		drain_results();
		apb_write(REG_SPARE_A, 32'hFFFF_FFFF);
		apb_write(REG_SPARE_B, 32'h0000_0000);
		read_back_regs();
		send_sample(16'sh0101);
		send_sample(16'shFEFE);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			c.enable = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 5))
				0:       c.base_delay = 20'd256;
				1:       c.base_delay = 20'd1048064;
				2:       c.base_delay = 20'($urandom_range(256, 1048064));
				default: c.base_delay = 20'($urandom_range(256, 64 * 256));
			endcase
			case ($urandom_range(0, 4))
				0:       c.mod_depth = '0;
				1:       c.mod_depth = 20'd524288;
				2:       c.mod_depth = 20'($urandom_range(0, 524288));
				default: c.mod_depth = 20'($urandom_range(0, c.base_delay));
			endcase
			case ($urandom_range(0, 3))
				0:       c.lfo_step = '0;
				1:       c.lfo_step = 32'hFFFF_FFFF;
				2:       c.lfo_step = $urandom;
				default: c.lfo_step = 32'($urandom_range(1, 1 << 24));
			endcase
			c.dry_gain = ($urandom_range(0, 5) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 32768));
			c.wet_gain = ($urandom_range(0, 5) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 32768));
			if (ph == 0) begin
				c = '{enable: 1'b1, base_delay: 20'd256, mod_depth: '0, lfo_step: '0,
					dry_gain: '0, wet_gain: '0};
			end else if (ph == 1) begin
				c = '{enable: 1'b1, base_delay: 20'd1048064, mod_depth: 20'd524288,
					lfo_step: 32'hFFFF_FFFF, dry_gain: 16'd32768, wet_gain: 16'd32768};
			end
			program_regs(c);
			quiet = (ph % 4 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 7))
					0:       v = 16'sh8000;
					1:       v = 16'sh7FFF;
					2:       v = 16'($urandom_range(0, 64)) - 16'sd32;
					default: v = 16'($urandom);
				endcase
				send_sample(v);
				if (ph == 5 && n == PHASE_ITEMS / 2) begin
					drain_results();
				end
			end
		end
		quiet = 1'b0;

		drain_results();
		repeat (20) @(posedge clk);
		$display("covered %0d samples and %0d results with %0d register writes",
			sample_count, result_count, write_count);
		$display("settings spanned pass-through, zero and clamped delays, extreme steps, hot gains");
		if (fail_count == 0 && pending == 0) begin
			$display("chorus_modulated_delay_unit regression: pass");
		end else begin
			$display("chorus_modulated_delay_unit regression: fail");
		end
		$finish;
	end

endmodule
